// File: rtl/sda_pkg.sv
`timescale 1ns / 1ps

package sda_pkg;

	localparam int MAX_SEGMENTS = 32;
	localparam int ID_BITS      = 8;
	localparam int IDX_W        = $clog2(MAX_SEGMENTS);
	localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
	localparam logic [15:0] CAPACITY_RESET = 16'd1024;

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_DELETE  = 2'd1,
		OP_SHOW    = 2'd2,
		OP_COMPACT = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_ID_ERROR   = 2'd1,
		ST_DISK_FULL  = 2'd2,
		ST_TABLE_FULL = 2'd3
	} status_t;

	typedef struct packed {
		logic [15:0]        start;
		logic [15:0]        size;
		logic               free;
		logic [ID_BITS-1:0] id;
	} seg_t;

endpackage

// File: rtl/segment_disk_allocator_top.sv
`timescale 1ns / 1ps
// Operation: write, delete and compact scan the table entry by entry, decide, then
// rebuild it into the other memory (one extra entry for a split), then flush, add the free
// tail (compact only) and finish before the result word; the table holds at most 32 entries.
// Show scans the table, then reads it again up to the last match; an output stall holds it.
// Throughput: one input word at a time; the next is taken once the last result is out.
// Reset: the table is one free segment of 1024 units; no clearing pass is needed.

module segment_disk_allocator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] file_id, [23:8] request_size
	input  logic [1:0]  s_tuser,   // [1:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] segment_start
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	typedef enum logic [11:0] {
		S_IDLE     = 12'b000000000001,
		S_SC_RD    = 12'b000000000010,
		S_SC_DAT   = 12'b000000000100,
		S_DECIDE   = 12'b000000001000,
		S_RW_RD    = 12'b000000010000,
		S_RW_DAT   = 12'b000000100000,
		S_RW_EXTRA = 12'b000001000000,
		S_RW_FLUSH = 12'b000010000000,
		S_RW_TAIL  = 12'b000100000000,
		S_RW_FIN   = 12'b001000000000,
		S_SH_RD    = 12'b010000000000,
		S_SH_DAT   = 12'b100000000000
	} state_t;

	localparam logic [sda_pkg::CNT_W-1:0] MAX_CNT = sda_pkg::CNT_W'(sda_pkg::MAX_SEGMENTS);

	state_t state_q;
	logic   resp_pend_q;

	sda_pkg::seg_t mem0 [sda_pkg::MAX_SEGMENTS];
	sda_pkg::seg_t mem1 [sda_pkg::MAX_SEGMENTS];
	sda_pkg::seg_t rdata0_q, rdata1_q;
	logic          sel_q, init_q;

	logic [15:0]                capacity_q;
	logic [sda_pkg::CNT_W-1:0]  count_q, i_q, j_q;
	logic [1:0]                 op_q;
	logic [sda_pkg::ID_BITS-1:0] id_q;
	logic [15:0]                req_q, rem_q, extra_q, ff_size_q;
	logic                       exists_q, ff_found_q, need_q, ff_mode_q;
	logic [16:0]                total_q, p_q;
	logic [sda_pkg::IDX_W-1:0]  ff_idx_q, last_match_q;
	logic [1:0]                 status_q;
	sda_pkg::seg_t              hold_q;
	logic                       hold_v_q;

	logic                       out_free;
	sda_pkg::seg_t              ent;
	logic                       match;
	logic [sda_pkg::IDX_W-1:0]  i_idx;
	logic [sda_pkg::CNT_W-1:0]  i_next;

	logic                       alloc;
	logic [15:0]                alloc_w;
	logic                       emit_v, merge, wr_en;
	sda_pkg::seg_t              emit_e, wr_data;

	assign out_free = !m_tvalid || m_tready;
	assign s_tready = (state_q == S_IDLE) && !resp_pend_q;
	assign i_idx    = i_q[sda_pkg::IDX_W-1:0];
	assign i_next   = i_q + 1'b1;

	always_comb begin
		ent = sel_q ? rdata1_q : rdata0_q;
		if (init_q) begin
			ent = '{start: 16'd0, size: capacity_q, free: 1'b1, id: '0};
		end
	end
	assign match = !ent.free && (ent.id == id_q);

	assign alloc   = (op_q == sda_pkg::OP_WRITE) && ent.free && (rem_q != 16'd0)
		&& (!ff_mode_q || i_idx == ff_idx_q);
	assign alloc_w = (rem_q < ent.size) ? rem_q : ent.size;

	// next entry handed to the rebuild buffer
	always_comb begin
		emit_v = 1'b0;
		emit_e = ent;
		if (state_q == S_RW_DAT) begin
			emit_v = 1'b1;
			if (alloc) begin
				emit_e.free = 1'b0;
				emit_e.id   = id_q;
				emit_e.size = alloc_w;
			end else if (op_q == sda_pkg::OP_DELETE && match) begin
				emit_e.free = 1'b1;
				emit_e.id   = '0;
			end else if (op_q == sda_pkg::OP_COMPACT && ent.free) begin
				emit_v = 1'b0;
			end
		end else if (state_q == S_RW_EXTRA) begin
			emit_v = 1'b1;
			emit_e = '{start: 16'd0, size: extra_q, free: 1'b1, id: '0};
		end
	end

	assign merge = emit_v && hold_v_q &&
		((op_q == sda_pkg::OP_DELETE && hold_q.free && emit_e.free) ||
		 (op_q == sda_pkg::OP_COMPACT && !hold_q.free && !emit_e.free
			&& hold_q.id == emit_e.id));

	always_comb begin
		wr_en   = 1'b0;
		wr_data = hold_q;
		wr_data.start = p_q[15:0];
		case (state_q)
			S_RW_DAT, S_RW_EXTRA: wr_en = emit_v && hold_v_q && !merge;
			S_RW_FLUSH:           wr_en = hold_v_q;
			S_RW_TAIL: begin
				wr_en   = (p_q < {1'b0, capacity_q}) && (j_q < MAX_CNT);
				wr_data = '{start: p_q[15:0], size: capacity_q - p_q[15:0],
					free: 1'b1, id: '0};
			end
			default: wr_en = 1'b0;
		endcase
	end

	// table memories: source is sel_q, rebuild goes to the other
	always_ff @(posedge clk) begin
		rdata0_q <= mem0[i_idx];
		rdata1_q <= mem1[i_idx];
		if (wr_en) begin
			if (sel_q) begin
				mem0[j_q[sda_pkg::IDX_W-1:0]] <= wr_data;
			end else begin
				mem1[j_q[sda_pkg::IDX_W-1:0]] <= wr_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			resp_pend_q <= 1'b0;
			sel_q       <= 1'b0;
			init_q      <= 1'b1;
			capacity_q  <= sda_pkg::CAPACITY_RESET;
			count_q     <= sda_pkg::CNT_W'(1);
			m_tvalid    <= 1'b0;
			hold_v_q    <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
				count_q    <= sda_pkg::CNT_W'(1);
				init_q     <= 1'b1;
			end

			if (wr_en) begin
				j_q <= j_q + 1'b1;
				p_q <= p_q + {1'b0, wr_data.size};
			end
			if (merge) begin
				hold_q.size <= hold_q.size + emit_e.size;
			end else if (emit_v) begin
				hold_q   <= emit_e;
				hold_v_q <= 1'b1;
			end

			if (resp_pend_q && out_free) begin
				m_tvalid    <= 1'b1;
				m_tuser     <= status_q;
				m_tdata     <= 16'd0;
				m_tlast     <= 1'b1;
				resp_pend_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						op_q       <= s_tuser;
						id_q       <= s_tdata[7:0];
						req_q      <= s_tdata[23:8];
						rem_q      <= s_tdata[23:8];
						exists_q   <= 1'b0;
						ff_found_q <= 1'b0;
						need_q     <= 1'b0;
						total_q    <= '0;
						i_q        <= '0;
						state_q    <= (count_q == '0) ? S_DECIDE : S_SC_RD;
					end
				end
				S_SC_RD: state_q <= S_SC_DAT;
				S_SC_DAT: begin
					if (match) begin
						exists_q     <= 1'b1;
						last_match_q <= i_idx;
					end
					if (ent.free) begin
						total_q <= total_q + {1'b0, ent.size};
						if (!ff_found_q && ent.size >= req_q) begin
							ff_found_q <= 1'b1;
							ff_idx_q   <= i_idx;
							ff_size_q  <= ent.size;
						end
						if (rem_q != 16'd0) begin
							if (alloc_w < ent.size) need_q <= 1'b1;
							rem_q <= rem_q - alloc_w;
						end
					end
					i_q     <= i_next;
					state_q <= (i_next == count_q) ? S_DECIDE : S_SC_RD;
				end
				S_DECIDE: begin
					// defaults for a rebuild pass
					i_q       <= '0;
					j_q       <= '0;
					p_q       <= '0;
					hold_v_q  <= 1'b0;
					rem_q     <= req_q;
					ff_mode_q <= ff_found_q;
					status_q  <= sda_pkg::ST_OK;
					state_q   <= (count_q == '0) ? S_RW_FLUSH : S_RW_RD;
					case (op_q)
						sda_pkg::OP_WRITE: begin
							if (exists_q) begin
								status_q <= sda_pkg::ST_ID_ERROR;
								resp_pend_q <= 1'b1;
								state_q  <= S_IDLE;
							end else if (req_q == 16'd0) begin
								resp_pend_q <= 1'b1;
								state_q  <= S_IDLE;
							end else if (total_q < {1'b0, req_q}) begin
								status_q <= sda_pkg::ST_DISK_FULL;
								resp_pend_q <= 1'b1;
								state_q  <= S_IDLE;
							end else if ((ff_found_q ? (ff_size_q != req_q) : need_q)
									&& count_q >= MAX_CNT) begin
								status_q <= sda_pkg::ST_TABLE_FULL;
								resp_pend_q <= 1'b1;
								state_q  <= S_IDLE;
							end
						end
						sda_pkg::OP_DELETE: begin
							if (!exists_q) begin
								status_q <= sda_pkg::ST_ID_ERROR;
								resp_pend_q <= 1'b1;
								state_q  <= S_IDLE;
							end
						end
						sda_pkg::OP_SHOW: begin
							if (!exists_q) begin
								status_q <= sda_pkg::ST_ID_ERROR;
								resp_pend_q <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								state_q <= S_SH_RD;
							end
						end
						default: ;
					endcase
				end
				S_RW_RD: state_q <= S_RW_DAT;
				S_RW_DAT: begin
					if (alloc) begin
						rem_q <= rem_q - alloc_w;
					end
					if (alloc && alloc_w != ent.size) begin
						extra_q <= ent.size - alloc_w;
						state_q <= S_RW_EXTRA;
					end else begin
						i_q     <= i_next;
						state_q <= (i_next == count_q) ? S_RW_FLUSH : S_RW_RD;
					end
				end
				S_RW_EXTRA: begin
					i_q     <= i_next;
					state_q <= (i_next == count_q) ? S_RW_FLUSH : S_RW_RD;
				end
				S_RW_FLUSH: begin
					hold_v_q <= 1'b0;
					state_q  <= (op_q == sda_pkg::OP_COMPACT) ? S_RW_TAIL : S_RW_FIN;
				end
				S_RW_TAIL: state_q <= S_RW_FIN;
				S_RW_FIN: begin
					count_q     <= j_q;
					sel_q       <= !sel_q;
					init_q      <= 1'b0;
					resp_pend_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_SH_RD: state_q <= S_SH_DAT;
				S_SH_DAT: begin
					if (!match || out_free) begin
						if (match) begin
							m_tvalid <= 1'b1;
							m_tuser  <= sda_pkg::ST_OK;
							m_tdata  <= ent.start;
							m_tlast  <= (i_idx == last_match_q);
						end
						i_q     <= i_next;
						state_q <= (i_idx == last_match_q) ? S_IDLE : S_SH_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int NSEG      = sda_pkg::MAX_SEGMENTS;
	localparam int STALL_MAX = 20000;

	typedef struct {
		sda_pkg::status_t status;
		logic [15:0]      start;
		logic             last;
	} seg_result_t;

	// Table shadow plus the queue of results still owed by the block.
	class alloc_scoreboard;
		int unsigned seg_start[NSEG], seg_size[NSEG], seg_owner[NSEG];
		bit          seg_free[NSEG];
		int unsigned seg_cnt, disk_cap;
		seg_result_t owed_q[$];
		int          n_err, n_checked;

		function new();
			disk_cap = sda_pkg::CAPACITY_RESET;
			n_err = 0;
			n_checked = 0;
			clear_table();
		endfunction

		function void clear_table();
			for (int i = 0; i < NSEG; i++) begin
				seg_start[i] = 0; seg_size[i] = 0; seg_owner[i] = 0; seg_free[i] = 0;
			end
			seg_free[0] = 1;
			seg_size[0] = disk_cap;
			seg_cnt = 1;
		endfunction

		function void set_capacity(int unsigned v);
			disk_cap = v & 16'hFFFF;
			clear_table();
		endfunction

		function void renumber();
			int unsigned p;
			p = 0;
			for (int i = 0; i < seg_cnt; i++) begin
				seg_start[i] = p & 16'hFFFF;
				p += seg_size[i];
			end
		endfunction

		function bit owns_any(int unsigned id);
			for (int i = 0; i < seg_cnt; i++)
				if (!seg_free[i] && seg_owner[i] == id) return 1;
			return 0;
		endfunction

		function void open_gap(int unsigned k, int unsigned sz);
			if (seg_cnt >= NSEG || k > seg_cnt) return;
			for (int j = seg_cnt; j > k; j--) begin
				seg_start[j] = seg_start[j-1]; seg_size[j] = seg_size[j-1];
				seg_owner[j] = seg_owner[j-1]; seg_free[j] = seg_free[j-1];
			end
			seg_free[k] = 1; seg_owner[k] = 0; seg_size[k] = sz; seg_start[k] = 0;
			seg_cnt++;
		endfunction

		function sda_pkg::status_t alloc_file(int unsigned id, int unsigned sz);
			int unsigned total, left, w, r;
			int          i;
			bit          split_needed;
			total = 0;
			split_needed = 0;
			if (owns_any(id)) return sda_pkg::ST_ID_ERROR;
			if (sz == 0) return sda_pkg::ST_OK;
			for (i = 0; i < seg_cnt; i++)
				if (seg_free[i]) total += seg_size[i];
			if (total < sz) return sda_pkg::ST_DISK_FULL;
			// first fit
			for (i = 0; i < seg_cnt; i++) begin
				if (seg_free[i] && seg_size[i] >= sz) begin
					r = seg_size[i] - sz;
					if (r != 0 && seg_cnt >= NSEG) return sda_pkg::ST_TABLE_FULL;
					seg_free[i] = 0; seg_owner[i] = id; seg_size[i] = sz;
					if (r != 0) open_gap(i + 1, r);
					renumber();
					return sda_pkg::ST_OK;
				end
			end
			// scatter over free segments; only the last one may split
			left = sz;
			for (i = 0; i < seg_cnt && left != 0; i++) begin
				if (seg_free[i]) begin
					w = left < seg_size[i] ? left : seg_size[i];
					if (w < seg_size[i]) split_needed = 1;
					left -= w;
				end
			end
			if (split_needed && seg_cnt >= NSEG) return sda_pkg::ST_TABLE_FULL;
			left = sz;
			for (i = 0; i < seg_cnt && left != 0; i++) begin
				if (seg_free[i]) begin
					w = left < seg_size[i] ? left : seg_size[i];
					r = seg_size[i] - w;
					seg_free[i] = 0; seg_owner[i] = id; seg_size[i] = w;
					left -= w;
					if (r != 0) begin
						open_gap(i + 1, r);
						i++;
					end
				end
			end
			renumber();
			return sda_pkg::ST_OK;
		endfunction

		function sda_pkg::status_t free_file(int unsigned id);
			int unsigned n;
			n = 0;
			if (!owns_any(id)) return sda_pkg::ST_ID_ERROR;
			for (int i = 0; i < seg_cnt; i++)
				if (!seg_free[i] && seg_owner[i] == id) begin
					seg_free[i] = 1; seg_owner[i] = 0;
				end
			for (int i = 0; i < seg_cnt; i++) begin
				if (n > 0 && seg_free[i] && seg_free[n-1])
					seg_size[n-1] += seg_size[i];
				else begin
					seg_start[n] = seg_start[i]; seg_size[n] = seg_size[i];
					seg_owner[n] = seg_owner[i]; seg_free[n] = seg_free[i];
					n++;
				end
			end
			seg_cnt = n;
			renumber();
			return sda_pkg::ST_OK;
		endfunction

		function void pack_table();
			int unsigned psz[NSEG], pown[NSEG];
			bit          pfree[NSEG];
			int unsigned n, p;
			n = 0;
			p = 0;
			for (int i = 0; i < seg_cnt; i++) begin
				if (seg_free[i]) continue;
				if (n > 0 && pown[n-1] == seg_owner[i])
					psz[n-1] += seg_size[i];
				else begin
					psz[n] = seg_size[i]; pown[n] = seg_owner[i]; pfree[n] = 0;
					n++;
				end
				p += seg_size[i];
			end
			if (p < disk_cap && n < NSEG) begin
				psz[n] = disk_cap - p; pown[n] = 0; pfree[n] = 1;
				n++;
			end
			for (int i = 0; i < n; i++) begin
				seg_size[i] = psz[i]; seg_owner[i] = pown[i]; seg_free[i] = pfree[i];
			end
			seg_cnt = n;
			renumber();
		endfunction

		function void owe(sda_pkg::status_t s, int unsigned start, bit last);
			seg_result_t e;
			e.status = s;
			e.start = start[15:0];
			e.last = last;
			owed_q = {owed_q, e};
		endfunction

		function void note_word(sda_pkg::op_t op, logic [7:0] id, logic [15:0] sz);
			case (op)
				sda_pkg::OP_WRITE:  owe(alloc_file(id, sz), 0, 1);
				sda_pkg::OP_DELETE: owe(free_file(id), 0, 1);
				sda_pkg::OP_SHOW: begin
					if (!owns_any(id)) owe(sda_pkg::ST_ID_ERROR, 0, 1);
					else begin
						for (int i = 0; i < seg_cnt; i++)
							if (!seg_free[i] && seg_owner[i] == id)
								owe(sda_pkg::ST_OK, seg_start[i], 0);
						owed_q[owed_q.size()-1].last = 1;
					end
				end
				default: begin
					pack_table();
					owe(sda_pkg::ST_OK, 0, 1);
				end
			endcase
		endfunction

		task report(string msg);
			$display("mismatch @%0t: %s", $realtime, msg);
			n_err++;
		endtask

		task check_word(logic [1:0] st, logic [15:0] start, logic last);
			seg_result_t e;
			n_checked++;
			if (owed_q.size() == 0) begin
				report($sformatf("unexpected word status=%0d start=%0d last=%0d",
					st, start, last));
				return;
			end
			e = owed_q.pop_front();
			if (st !== e.status)
				report($sformatf("status got %0d want %0d", st, e.status));
			if (start !== e.start)
				report($sformatf("segment_start got %0d want %0d", start, e.start));
			if (last !== e.last)
				report($sformatf("tlast got %0d want %0d", last, e.last));
		endtask
	endclass

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;
	logic [1:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we    = 1'b0;
	logic [15:0] cfg_wdata = '0;

	alloc_scoreboard sb = new();
	int  hold_len = 0;
	bit  quiet = 0;
	int  n_words_in = 0;
	int  n_cfg = 0;
	int  stall_cnt = 0;

	segment_disk_allocator_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk)
		if (m_tvalid && m_tready) sb.check_word(m_tuser, m_tdata, m_tlast);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt > STALL_MAX) begin
			$display("timeout: no traffic for %0d cycles", STALL_MAX);
			$display("[segment_disk_allocator_top] ERROR");
			$finish;
		end
	end

	// receiver: random ready bursts, one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_len > 0) begin
				m_tready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else if (quiet) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_tready <= ($urandom_range(0, 2) != 0);
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
		end
	end

	task automatic send(sda_pkg::op_t op, logic [7:0] id, logic [15:0] sz);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {sz, id};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_word(op, id, sz);
		n_words_in++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.owed_q.size() != 0) @(posedge clk);
	endtask

	task automatic set_cap(logic [15:0] v);
		drain();
		// quiet gap before the register write
		repeat (200) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_capacity(v);
		n_cfg++;
	endtask

	task automatic random_word(int unsigned cap);
		sda_pkg::op_t op;
		logic [7:0]   id;
		logic [15:0]  sz;
		int           pick;
		pick = $urandom_range(0, 99);
		op = pick < 45 ? sda_pkg::OP_WRITE : pick < 70 ? sda_pkg::OP_DELETE :
			pick < 90 ? sda_pkg::OP_SHOW : sda_pkg::OP_COMPACT;
		id = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 15)) : 8'($urandom);
		pick = $urandom_range(0, 9);
		if (pick < 6)      sz = 16'($urandom_range(1, cap / 8 + 1));
		else if (pick < 8) sz = 16'($urandom_range(1, cap > 0 ? cap : 1));
		else if (pick < 9) sz = 16'd0;
		else               sz = 16'($urandom);
		send(op, id, sz);
	endtask

	initial begin : main
		int caps[8];
		caps = '{1024, 64, 200, 65535, 48, 0, 1, 500};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: missing ids, zero size, duplicates, full disk, exact fill
		send(sda_pkg::OP_SHOW, 8'd5, 16'd0);
		send(sda_pkg::OP_DELETE, 8'd5, 16'd0);
		send(sda_pkg::OP_WRITE, 8'd0, 16'd0);
		send(sda_pkg::OP_WRITE, 8'd255, 16'd100);
		send(sda_pkg::OP_WRITE, 8'd255, 16'd1);
		send(sda_pkg::OP_WRITE, 8'd1, 16'hFFFF);
		send(sda_pkg::OP_WRITE, 8'd2, 16'd924);
		send(sda_pkg::OP_SHOW, 8'd255, 16'hFFFF);
		send(sda_pkg::OP_DELETE, 8'd255, 16'd0);
		send(sda_pkg::OP_WRITE, 8'd3, 16'd30);
		send(sda_pkg::OP_DELETE, 8'd2, 16'd0);
		send(sda_pkg::OP_WRITE, 8'd4, 16'd1000);
		send(sda_pkg::OP_SHOW, 8'd4, 16'd0);
		send(sda_pkg::OP_COMPACT, 8'd0, 16'd0);
		send(sda_pkg::OP_SHOW, 8'd4, 16'd0);
		set_cap(16'd0);
		send(sda_pkg::OP_WRITE, 8'd9, 16'd5);
		send(sda_pkg::OP_WRITE, 8'd9, 16'd0);
		send(sda_pkg::OP_COMPACT, 8'd0, 16'd0);
		send(sda_pkg::OP_SHOW, 8'd9, 16'd0);
		send(sda_pkg::OP_WRITE, 8'd9, 16'd1);
		set_cap(16'hFFFF);
		send(sda_pkg::OP_WRITE, 8'd10, 16'hFFFF);
		send(sda_pkg::OP_SHOW, 8'd10, 16'd0);
		send(sda_pkg::OP_WRITE, 8'd11, 16'd1);

		// fill the table with one-unit files, then flood with shows while output stalls
		set_cap(16'd64);
		for (int i = 0; i < 34; i++) send(sda_pkg::OP_WRITE, 8'(i + 16), 16'd1);
		hold_len = 400;
		for (int i = 0; i < 20; i++) send(sda_pkg::OP_SHOW, 8'(i + 16), 16'd0);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			set_cap(16'(caps[ph]));
			if (ph == 7) quiet = 1;
			repeat (ph == 5 || ph == 6 ? 25 : 60) random_word(caps[ph]);
		end

		drain();
		repeat (200) @(posedge clk);
		$display("covered %0d input words, %0d result words, %0d capacity writes",
			n_words_in, sb.n_checked, n_cfg);
		$display("mismatches: %0d", sb.n_err);
		if (sb.n_err == 0 && sb.owed_q.size() == 0)
			$display("[segment_disk_allocator_top] OK");
		else
			$display("[segment_disk_allocator_top] ERROR");
		$finish;
	end

endmodule
